// File: rtl/core/gflw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gflw_pkg
// Shared constants, types and codes of the four-connected line walk.
// ----------------------------------------------------------------------------
package gflw_pkg;

   // largest span allowed on either axis
   localparam int MAX_SPAN = 31;

   // coordinate width of every point field
   localparam int COORD_W = 8;
   // width of one axis span after classification
   localparam int SPAN_W = $clog2(MAX_SPAN + 1);
   // width of step offsets and of the result counter
   localparam int OFF_W = $clog2(2 * MAX_SPAN + 1);
   // width of the signed cross product error term, with headroom for one add
   localparam int ERR_W = $clog2(2 * MAX_SPAN * MAX_SPAN + 1) + 2;
   // index of the final possible result of one walk
   localparam int LAST_STEP = 2 * MAX_SPAN - 1;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // classified request handed from front to back
   typedef struct packed {
      logic                       is_error;
      logic                       go_left;
      logic signed [COORD_W-1:0]  start_x;
      logic signed [COORD_W-1:0]  start_y;
      logic signed [COORD_W-1:0]  start_z;
      logic        [SPAN_W-1:0]   span_x;
      logic        [SPAN_W-1:0]   span_y;
   } cmd_type;

   // one result beat
   typedef struct packed {
      logic signed [COORD_W-1:0]  center_x;
      logic signed [COORD_W-1:0]  center_y;
      logic signed [COORD_W-1:0]  center_z;
      logic                       roll_horizontal;
      logic                       path_error;
      logic                       last;
   } rsp_type;

   // back unit sequencer
   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } back_state_type;

endpackage : gflw_pkg
`default_nettype wire

// File: rtl/core/gflw_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gflw_req_if
// Request channel: start point, goal point and horizontal direction.
// ----------------------------------------------------------------------------
interface gflw_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [gflw_pkg::COORD_W-1:0] start_x;
   logic signed [gflw_pkg::COORD_W-1:0] start_y;
   logic signed [gflw_pkg::COORD_W-1:0] start_z;
   logic signed [gflw_pkg::COORD_W-1:0] goal_x;
   logic signed [gflw_pkg::COORD_W-1:0] goal_y;
   logic signed [gflw_pkg::COORD_W-1:0] goal_z;
   logic                                go_left;

   modport source (
      output valid, start_x, start_y, start_z, goal_x, goal_y, goal_z, go_left,
      input  ready
   );
   modport sink (
      input  valid, start_x, start_y, start_z, goal_x, goal_y, goal_z, go_left,
      output ready
   );
endinterface : gflw_req_if
`default_nettype wire

// File: rtl/core/gflw_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gflw_rsp_if
// Result channel: one visited centre per beat.
// ----------------------------------------------------------------------------
interface gflw_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [gflw_pkg::COORD_W-1:0] center_x;
   logic signed [gflw_pkg::COORD_W-1:0] center_y;
   logic signed [gflw_pkg::COORD_W-1:0] center_z;
   logic                                roll_horizontal;
   logic                                path_error;
   logic                                last;

   modport source (
      output valid, center_x, center_y, center_z, roll_horizontal, path_error, last,
      input  ready
   );
   modport sink (
      input  valid, center_x, center_y, center_z, roll_horizontal, path_error, last,
      output ready
   );
endinterface : gflw_rsp_if
`default_nettype wire

// File: rtl/core/gflw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gflw_front
// Accepts request beats and classifies them into walk, error or empty runs.
// ----------------------------------------------------------------------------
module gflw_front (
   gflw_req_if.sink            req_bus,
   input  logic                q_full,
   output logic                push,
   output gflw_pkg::cmd_type   push_cmd
);

   logic signed [gflw_pkg::COORD_W:0] diff_x;
   logic signed [gflw_pkg::COORD_W:0] diff_y;
   logic                              z_differs;
   logic                              is_empty;
   logic                              out_of_range;

   // spans along the chosen direction and upward
   always_comb begin
      if (req_bus.go_left) begin
         diff_x = $signed({req_bus.start_x[gflw_pkg::COORD_W-1], req_bus.start_x})
                - $signed({req_bus.goal_x[gflw_pkg::COORD_W-1], req_bus.goal_x});
      end else begin
         diff_x = $signed({req_bus.goal_x[gflw_pkg::COORD_W-1], req_bus.goal_x})
                - $signed({req_bus.start_x[gflw_pkg::COORD_W-1], req_bus.start_x});
      end
      diff_y = $signed({req_bus.goal_y[gflw_pkg::COORD_W-1], req_bus.goal_y})
             - $signed({req_bus.start_y[gflw_pkg::COORD_W-1], req_bus.start_y});
   end

   // classification
   assign z_differs    = (req_bus.goal_z != req_bus.start_z);
   assign is_empty     = (diff_x == '0) && (diff_y == '0) && !z_differs;
   assign out_of_range = diff_x[gflw_pkg::COORD_W] || diff_y[gflw_pkg::COORD_W]
                      || (diff_x > $signed((gflw_pkg::COORD_W+1)'(gflw_pkg::MAX_SPAN)))
                      || (diff_y > $signed((gflw_pkg::COORD_W+1)'(gflw_pkg::MAX_SPAN)));

   // handshake: a start-equals-goal request is taken and dropped
   assign req_bus.ready = !q_full;
   assign push          = req_bus.valid && !q_full && !is_empty;

   // command for the back unit
   always_comb begin
      push_cmd.is_error = z_differs || out_of_range;
      push_cmd.go_left  = req_bus.go_left;
      push_cmd.start_x  = req_bus.start_x;
      push_cmd.start_y  = req_bus.start_y;
      push_cmd.start_z  = req_bus.start_z;
      push_cmd.span_x   = diff_x[gflw_pkg::SPAN_W-1:0];
      push_cmd.span_y   = diff_y[gflw_pkg::SPAN_W-1:0];
   end

endmodule : gflw_front
`default_nettype wire

// File: rtl/core/gflw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gflw_queue
// Short command queue that lets front and back stall on their own.
// ----------------------------------------------------------------------------
module gflw_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  gflw_pkg::cmd_type  push_cmd,
   input  logic               pop,
   output logic               q_full,
   output logic               q_valid,
   output gflw_pkg::cmd_type  q_cmd
);

   gflw_pkg::cmd_type                 entry_ff [gflw_pkg::QUEUE_DEPTH];
   logic [gflw_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [gflw_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [gflw_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign q_full  = (count_ff == gflw_pkg::QCNT_W'(gflw_pkg::QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push && !q_full;
   assign do_pop  = pop && q_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == gflw_pkg::QPTR_W'(gflw_pkg::QUEUE_DEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == gflw_pkg::QPTR_W'(gflw_pkg::QUEUE_DEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule : gflw_queue
`default_nettype wire

// File: rtl/core/gflw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gflw_back
// Walks one queued command, one lattice step per result beat.
// ----------------------------------------------------------------------------
module gflw_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  gflw_pkg::cmd_type  q_cmd,
   output logic               pop,
   gflw_rsp_if.source         rsp_bus
);

   gflw_pkg::back_state_type              state_ff, state_in;
   logic                                  out_valid_ff, out_valid_in;
   gflw_pkg::rsp_type                     out_ff, out_in;

   logic signed [gflw_pkg::COORD_W-1:0]   cur_x_ff, cur_x_in;
   logic signed [gflw_pkg::COORD_W-1:0]   cur_y_ff, cur_y_in;
   logic signed [gflw_pkg::COORD_W-1:0]   cur_z_ff, cur_z_in;
   logic                                  left_ff, left_in;
   logic [gflw_pkg::SPAN_W-1:0]           span_x_ff, span_x_in;
   logic [gflw_pkg::SPAN_W-1:0]           span_y_ff, span_y_in;
   logic [gflw_pkg::OFF_W-1:0]            off_x_ff, off_x_in;
   logic [gflw_pkg::OFF_W-1:0]            off_y_ff, off_y_in;
   logic [gflw_pkg::OFF_W-1:0]            count_ff, count_in;
   logic signed [gflw_pkg::ERR_W-1:0]     err_ff, err_in;

   logic                                  advance;
   logic signed [gflw_pkg::ERR_W-1:0]     span_x_ext;
   logic signed [gflw_pkg::ERR_W-1:0]     span_y_ext;
   logic signed [gflw_pkg::ERR_W-1:0]     horiz_err;
   logic signed [gflw_pkg::ERR_W-1:0]     up_err;
   logic [gflw_pkg::ERR_W-1:0]            horiz_mag;
   logic [gflw_pkg::ERR_W-1:0]            up_mag;
   logic                                  step_up;
   logic [gflw_pkg::OFF_W-1:0]            step_off_x;
   logic [gflw_pkg::OFF_W-1:0]            step_off_y;
   logic signed [gflw_pkg::COORD_W-1:0]   step_x;
   logic signed [gflw_pkg::COORD_W-1:0]   step_y;
   logic                                  step_last;

   // output slot frees when empty or being taken
   assign advance = !out_valid_ff || rsp_bus.ready;

   // cross product of each candidate against the line, kept incrementally
   assign span_x_ext = $signed(gflw_pkg::ERR_W'(span_x_ff));
   assign span_y_ext = $signed(gflw_pkg::ERR_W'(span_y_ff));
   assign horiz_err  = err_ff + span_y_ext;
   assign up_err     = err_ff - span_x_ext;
   assign horiz_mag  = horiz_err[gflw_pkg::ERR_W-1] ? gflw_pkg::ERR_W'(-horiz_err)
                                                   : gflw_pkg::ERR_W'(horiz_err);
   assign up_mag     = up_err[gflw_pkg::ERR_W-1] ? gflw_pkg::ERR_W'(-up_err)
                                                : gflw_pkg::ERR_W'(up_err);
   // tie goes horizontal
   assign step_up    = (horiz_mag > up_mag);

   // next position and end of walk
   assign step_off_x = step_up ? off_x_ff : off_x_ff + 1'b1;
   assign step_off_y = step_up ? off_y_ff + 1'b1 : off_y_ff;
   assign step_y     = step_up ? cur_y_ff + 1'b1 : cur_y_ff;
   always_comb begin
      if (step_up) begin
         step_x = cur_x_ff;
      end else if (left_ff) begin
         step_x = cur_x_ff - 1'b1;
      end else begin
         step_x = cur_x_ff + 1'b1;
      end
   end
   assign step_last = ((step_off_x == gflw_pkg::OFF_W'(span_x_ff))
                    && (step_off_y == gflw_pkg::OFF_W'(span_y_ff)))
                   || (count_ff == gflw_pkg::OFF_W'(gflw_pkg::LAST_STEP));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      out_in       = out_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      cur_z_in     = cur_z_ff;
      left_in      = left_ff;
      span_x_in    = span_x_ff;
      span_y_in    = span_y_ff;
      off_x_in     = off_x_ff;
      off_y_in     = off_y_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      pop          = 1'b0;
      unique case (state_ff)
         gflw_pkg::ST_IDLE: begin
            if (q_valid && advance) begin
               pop = 1'b1;
               if (q_cmd.is_error) begin
                  // rejected request: single beat at the start point
                  out_in.center_x        = q_cmd.start_x;
                  out_in.center_y        = q_cmd.start_y;
                  out_in.center_z        = q_cmd.start_z;
                  out_in.roll_horizontal = 1'b0;
                  out_in.path_error      = 1'b1;
                  out_in.last            = 1'b1;
                  out_valid_in           = 1'b1;
               end else begin
                  cur_x_in  = q_cmd.start_x;
                  cur_y_in  = q_cmd.start_y;
                  cur_z_in  = q_cmd.start_z;
                  left_in   = q_cmd.go_left;
                  span_x_in = q_cmd.span_x;
                  span_y_in = q_cmd.span_y;
                  off_x_in  = '0;
                  off_y_in  = '0;
                  count_in  = '0;
                  err_in    = '0;
                  state_in  = gflw_pkg::ST_WALK;
               end
            end
         end
         gflw_pkg::ST_WALK: begin
            if (advance) begin
               out_in.center_x        = step_x;
               out_in.center_y        = step_y;
               out_in.center_z        = cur_z_ff;
               out_in.roll_horizontal = !step_up;
               out_in.path_error      = 1'b0;
               out_in.last            = step_last;
               out_valid_in           = 1'b1;
               cur_x_in               = step_x;
               cur_y_in               = step_y;
               off_x_in               = step_off_x;
               off_y_in               = step_off_y;
               count_in               = count_ff + 1'b1;
               err_in                 = step_up ? up_err : horiz_err;
               if (step_last) begin
                  state_in = gflw_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = gflw_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gflw_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // walk and result payload registers
   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      cur_x_ff  <= cur_x_in;
      cur_y_ff  <= cur_y_in;
      cur_z_ff  <= cur_z_in;
      left_ff   <= left_in;
      span_x_ff <= span_x_in;
      span_y_ff <= span_y_in;
      off_x_ff  <= off_x_in;
      off_y_ff  <= off_y_in;
      count_ff  <= count_in;
      err_ff    <= err_in;
   end

   // result channel
   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.center_x        = out_ff.center_x;
   assign rsp_bus.center_y        = out_ff.center_y;
   assign rsp_bus.center_z        = out_ff.center_z;
   assign rsp_bus.roll_horizontal = out_ff.roll_horizontal;
   assign rsp_bus.path_error      = out_ff.path_error;
   assign rsp_bus.last            = out_ff.last;

endmodule : gflw_back
`default_nettype wire

// File: rtl/core/greedy_four_connected_line_walk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_four_connected_line_walk
// Greedy 4-connected lattice walk from a start point to a goal point.
// ----------------------------------------------------------------------------
// Each request beat names a start, a goal and a horizontal direction; the
// block answers with one result beat per visited centre (start excluded, goal
// included), each marking a horizontal or an up step, with last set on the
// final one. A goal below the start, on the wrong side, at another z, or
// farther than MAX_SPAN on either axis gives a single beat with path_error
// and last set at the start point; start equal to goal gives no beat at all.
// The front takes a request into a two-entry queue when the queue has room;
// the back loads a walk from the queue and then gives one result beat per
// step, at most 62 steps; an error command gives its single beat as it is
// loaded. A stall on the result side holds the back where it is.
// ----------------------------------------------------------------------------
module greedy_four_connected_line_walk (
   input  logic          clock,
   input  logic          reset,
   gflw_req_if.sink      req_bus,
   gflw_rsp_if.source    rsp_bus
);

   logic               push;
   gflw_pkg::cmd_type  push_cmd;
   logic               q_full;
   logic               q_valid;
   gflw_pkg::cmd_type  q_cmd;
   logic               pop;

   // request intake and classification
   gflw_front u_front (
      .req_bus  (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   // command queue
   gflw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_full   (q_full),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd)
   );

   // step walker and result register
   gflw_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_cmd),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule : greedy_four_connected_line_walk
`default_nettype wire

// File: rtl/core/gflw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gflw_checker
// Port-level checks on the result channel of the line walk.
// ----------------------------------------------------------------------------
module gflw_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [gflw_pkg::COORD_W-1:0] center_x,
   input  logic signed [gflw_pkg::COORD_W-1:0] center_y,
   input  logic signed [gflw_pkg::COORD_W-1:0] center_z,
   input  logic                                roll_horizontal,
   input  logic                                path_error,
   input  logic                                last
);

   // an error beat always closes its run
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && path_error |-> last)
      else $error("error beat without last");

   // an error beat carries no roll step
   a_error_no_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && path_error |-> !roll_horizontal)
      else $error("error beat with horizontal roll");

   // a walk beat taken before the end is followed at once by another walk beat
   a_walk_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !last |=> rsp_valid && !path_error
         && $stable(center_z))
      else $error("walk broken before its last beat");

   // a stalled beat holds
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(center_x) && $stable(center_y)
         && $stable(last))
      else $error("stalled result beat changed");

endmodule : gflw_checker

bind greedy_four_connected_line_walk gflw_checker u_gflw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .center_x        (rsp_bus.center_x),
   .center_y        (rsp_bus.center_y),
   .center_z        (rsp_bus.center_z),
   .roll_horizontal (rsp_bus.roll_horizontal),
   .path_error      (rsp_bus.path_error),
   .last            (rsp_bus.last)
);
`default_nettype wire

// File: tb/greedy_four_connected_line_walk_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_four_connected_line_walk_tb
// Self-checking bench for the four-connected greedy line walk.
// ----------------------------------------------------------------------------
// A short table of hand-picked walks comes first. It covers empty walks, every
// way a request gets rejected, coordinate extremes, ties and the longest paths.
// Random walks follow: mostly legal ones, some broken on purpose, and some
// raw noise. Predicted rows and random requests go through a local walk model,
// other rows give their beat directly, and each result beat is compared field
// by field with the oldest predicted centre. Three traffic phases vary the
// backpressure on both sides; one long result-side stall backs requests up.
// ----------------------------------------------------------------------------
module greedy_four_connected_line_walk_tb;
   import gflw_pkg::*;

   // how a directed row is checked
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NO_BEAT,
      ROW_ONE_BEAT
   } row_check_type;

   // ways a random request is broken on purpose
   typedef enum logic [2:0] {
      BREAK_Z,
      BREAK_SPAN_X,
      BREAK_SPAN_Y,
      BREAK_BELOW,
      BREAK_SIDE
   } break_kind_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] start_x;
      logic signed [COORD_W-1:0] start_y;
      logic signed [COORD_W-1:0] start_z;
      logic signed [COORD_W-1:0] goal_x;
      logic signed [COORD_W-1:0] goal_y;
      logic signed [COORD_W-1:0] goal_z;
      logic                      go_left;
   } walk_req_type;

   typedef struct packed {
      walk_req_type  req;
      row_check_type check;
      rsp_type       beat;
   } walk_row_type;

   localparam int NUM_ROWS     = 23;
   localparam int PHASE_ITEMS  = 112;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset;

   gflw_req_if req_bus ();
   gflw_rsp_if rsp_bus ();

   greedy_four_connected_line_walk dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // predicted centers, oldest first
   rsp_type pending_centers [$];

   // traffic shaping, set by the stimulus
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_request  = 1'b0;

   // what the request in flight is checked against
   row_check_type cur_check = ROW_PREDICT;
   rsp_type       cur_beat  = '0;

   // run statistics
   int fail_count    = 0;
   int request_count = 0;
   int beat_count    = 0;
   int reject_count  = 0;
   int empty_count   = 0;
   int longest_walk  = 0;

   walk_row_type directed_rows [NUM_ROWS];

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int magnitude(input int v);
      return (v < 0) ? -v : v;
   endfunction

   // append one predicted centre at the young end
   function automatic void queue_center(input rsp_type b);
      pending_centers.insert(pending_centers.size(), b);
   endfunction

   // walk model: queue every centre the request visits
   function automatic void plan_walk(input walk_req_type q);
      int  sx, sy, sz, gx, gy, gz;
      int  dx, dy, ox, oy, n, off_h, off_u;
      bit  done;
      rsp_type b;
      sx = q.start_x;
      sy = q.start_y;
      sz = q.start_z;
      gx = q.goal_x;
      gy = q.goal_y;
      gz = q.goal_z;
      dx = q.go_left ? (sx - gx) : (gx - sx);
      dy = gy - sy;
      // empty walk
      if (dx == 0 && dy == 0 && gz == sz)
         return;
      // rejected request: one beat at the start point
      if (gz != sz || dx < 0 || dy < 0 || dx > MAX_SPAN || dy > MAX_SPAN) begin
         b.center_x        = q.start_x;
         b.center_y        = q.start_y;
         b.center_z        = q.start_z;
         b.roll_horizontal = 1'b0;
         b.path_error      = 1'b1;
         b.last            = 1'b1;
         queue_center(b);
         return;
      end
      ox   = 0;
      oy   = 0;
      n    = 0;
      done = 1'b0;
      // greedy step: go up only when horizontal is strictly farther off the line
      while (!done) begin
         off_h = magnitude((ox + 1) * dy - oy * dx);
         off_u = magnitude(ox * dy - (oy + 1) * dx);
         if (off_h > off_u) begin
            oy = oy + 1;
            b.roll_horizontal = 1'b0;
         end else begin
            ox = ox + 1;
            b.roll_horizontal = 1'b1;
         end
         done = (ox == dx && oy == dy) || n >= LAST_STEP;
         b.center_x   = COORD_W'(q.go_left ? sx - ox : sx + ox);
         b.center_y   = COORD_W'(sy + oy);
         b.center_z   = q.start_z;
         b.path_error = 1'b0;
         b.last       = done;
         queue_center(b);
         n = n + 1;
      end
      if (n > longest_walk)
         longest_walk = n;
   endfunction

   // random request: mostly legal walks, some broken ones, some noise
   function automatic walk_req_type random_request();
      walk_req_type q;
      int pick, dx, dy, lo, hi, sx, sy;
      pick = $urandom_range(99);
      q = walk_req_type'({$urandom, $urandom});
      if (pick >= 85)
         return q;
      dx = $urandom_range(MAX_SPAN);
      dy = $urandom_range(MAX_SPAN);
      if ($urandom_range(19) == 0) begin
         dx = MAX_SPAN;
         dy = MAX_SPAN;
      end
      q.goal_z = q.start_z;
      if (pick >= 75) begin
         case (break_kind_type'($urandom_range(4)))
            BREAK_Z:      q.goal_z = q.start_z ^ COORD_W'(1 << $urandom_range(7));
            BREAK_SPAN_X: dx = MAX_SPAN + 1 + $urandom_range(20);
            BREAK_SPAN_Y: dy = MAX_SPAN + 1 + $urandom_range(20);
            BREAK_BELOW:  dy = -1 - $urandom_range(7);
            default:      dx = -1 - $urandom_range(7);
         endcase
      end
      // place start so that the goal stays on the grid
      if (q.go_left) begin
         lo = -128 + ((dx > 0) ? dx : 0);
         hi = 127 - ((dx < 0) ? -dx : 0);
      end else begin
         lo = -128 + ((dx < 0) ? -dx : 0);
         hi = 127 - ((dx > 0) ? dx : 0);
      end
      sx = lo + $urandom_range(hi - lo);
      lo = -128 + ((dy < 0) ? -dy : 0);
      hi = 127 - ((dy > 0) ? dy : 0);
      sy = lo + $urandom_range(hi - lo);
      q.start_x = COORD_W'(sx);
      q.start_y = COORD_W'(sy);
      q.goal_x  = COORD_W'(q.go_left ? sx - dx : sx + dx);
      q.goal_y  = COORD_W'(sy + dy);
      return q;
   endfunction

   // compare one result beat with the oldest prediction
   task automatic check_beat(input rsp_type got);
      rsp_type want;
      want = pending_centers.pop_front();
      if (got.center_x !== want.center_x) begin
         $error("center_x expected %0d got %0d", want.center_x, got.center_x);
         fail_count++;
      end
      if (got.center_y !== want.center_y) begin
         $error("center_y expected %0d got %0d", want.center_y, got.center_y);
         fail_count++;
      end
      if (got.center_z !== want.center_z) begin
         $error("center_z expected %0d got %0d", want.center_z, got.center_z);
         fail_count++;
      end
      if (got.roll_horizontal !== want.roll_horizontal) begin
         $error("roll_horizontal expected %0b got %0b",
                want.roll_horizontal, got.roll_horizontal);
         fail_count++;
      end
      if (got.path_error !== want.path_error) begin
         $error("path_error expected %0b got %0b", want.path_error, got.path_error);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $error("last expected %0b got %0b", want.last, got.last);
         fail_count++;
      end
   endtask

   // request and result monitor
   always @(posedge clock) begin
      walk_req_type q;
      rsp_type      got;
      int           depth;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            q = '{req_bus.start_x, req_bus.start_y, req_bus.start_z,
                  req_bus.goal_x, req_bus.goal_y, req_bus.goal_z, req_bus.go_left};
            depth = pending_centers.size();
            case (cur_check)
               ROW_NO_BEAT:  ;
               ROW_ONE_BEAT: queue_center(cur_beat);
               default:      plan_walk(q);
            endcase
            request_count++;
            if (pending_centers.size() == depth)
               empty_count++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.center_x, rsp_bus.center_y, rsp_bus.center_z,
                    rsp_bus.roll_horizontal, rsp_bus.path_error, rsp_bus.last};
            beat_count++;
            if (got.path_error)
               reject_count++;
            if (pending_centers.size() == 0) begin
               $error("unexpected result beat at (%0d, %0d, %0d)",
                      got.center_x, got.center_y, got.center_z);
               fail_count++;
            end else begin
               check_beat(got);
            end
         end
      end
   end

   // result side: random stalls plus one long hold-off
   always @(negedge clock) begin
      static int  hold_left  = 0;
      static bit  hold_taken = 1'b0;
      if (hold_request && !hold_taken) begin
         hold_left  = HOLD_CYCLES;
         hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // drive one request beat; returns just after a falling edge
   task automatic send_request(input walk_req_type q, input row_check_type check,
                               input rsp_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      cur_check = check;
      cur_beat  = beat;
      req_bus.valid   <= 1'b1;
      req_bus.start_x <= q.start_x;
      req_bus.start_y <= q.start_y;
      req_bus.start_z <= q.start_z;
      req_bus.goal_x  <= q.goal_x;
      req_bus.goal_y  <= q.goal_y;
      req_bus.goal_z  <= q.goal_z;
      req_bus.go_left <= q.go_left;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // hold requests until every predicted centre has come out
   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (pending_centers.size() != 0)
         @(posedge clock);
      @(negedge clock);
   endtask

   // stimulus
   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.start_z = '0;
      req_bus.goal_x  = '0;
      req_bus.goal_y  = '0;
      req_bus.goal_z  = '0;
      req_bus.go_left = 1'b0;
      rsp_bus.ready   = 1'b0;

      directed_rows = '{
         // start equals goal, no beat
         '{'{0, 0, 0, 0, 0, 0, 0}, ROW_NO_BEAT, '0},
         '{'{-128, -128, -128, -128, -128, -128, 1}, ROW_NO_BEAT, '0},
         '{'{127, 127, 127, 127, 127, 127, 0}, ROW_NO_BEAT, '0},
         // goal at another z
         '{'{4, 4, 0, 4, 4, 1, 0}, ROW_ONE_BEAT, '{4, 4, 0, 0, 1, 1}},
         '{'{0, 0, 127, 2, 3, -128, 0}, ROW_ONE_BEAT, '{0, 0, 127, 0, 1, 1}},
         // goal below start
         '{'{0, 5, 0, 2, 0, 0, 0}, ROW_ONE_BEAT, '{0, 5, 0, 0, 1, 1}},
         // goal on the wrong side
         '{'{5, 0, 0, 2, 3, 0, 0}, ROW_ONE_BEAT, '{5, 0, 0, 0, 1, 1}},
         '{'{-5, 0, 0, -2, 3, 0, 1}, ROW_ONE_BEAT, '{-5, 0, 0, 0, 1, 1}},
         // span one over the bound
         '{'{0, 0, 0, 32, 0, 0, 0}, ROW_ONE_BEAT, '{0, 0, 0, 0, 1, 1}},
         '{'{0, 0, 0, 0, 32, 0, 1}, ROW_ONE_BEAT, '{0, 0, 0, 0, 1, 1}},
         // corner to corner
         '{'{-128, -128, -128, 127, 127, -128, 0}, ROW_ONE_BEAT,
           '{-128, -128, -128, 0, 1, 1}},
         '{'{127, -128, -1, -128, 127, -1, 1}, ROW_ONE_BEAT, '{127, -128, -1, 0, 1, 1}},
         // single steps
         '{'{0, 0, 5, 1, 0, 5, 0}, ROW_ONE_BEAT, '{1, 0, 5, 1, 0, 1}},
         '{'{0, 0, 5, -1, 0, 5, 1}, ROW_ONE_BEAT, '{-1, 0, 5, 1, 0, 1}},
         '{'{0, 0, -3, 0, 1, -3, 0}, ROW_ONE_BEAT, '{0, 1, -3, 0, 0, 1}},
         // tie on the diagonal
         '{'{0, 0, 0, 1, 1, 0, 0}, ROW_PREDICT, '0},
         // longest walks
         '{'{-128, -128, -128, -97, -97, -128, 0}, ROW_PREDICT, '0},
         '{'{127, 96, 127, 96, 127, 127, 1}, ROW_PREDICT, '0},
         // straight lines
         '{'{0, 0, 0, 31, 0, 0, 0}, ROW_PREDICT, '0},
         '{'{10, -20, 0, 10, 11, 0, 1}, ROW_PREDICT, '0},
         // shallow and steep slopes
         '{'{-50, 7, 9, -19, 8, 9, 0}, ROW_PREDICT, '0},
         '{'{60, -100, -77, 59, -69, -77, 1}, ROW_PREDICT, '0},
         // up to the grid edge
         '{'{100, 100, 1, 127, 127, 1, 0}, ROW_PREDICT, '0}
      };

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed walks
      send_idle_pct = 31;
      recv_idle_pct = 87;
      for (int i = 0; i < NUM_ROWS; i++)
         send_request(directed_rows[i].req, directed_rows[i].check,
                      directed_rows[i].beat);

      // random walks in three traffic phases
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 31;
               recv_idle_pct = 87;
            end
            1: begin
               send_idle_pct = 87;
               recv_idle_pct = 31;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_request  = 1'b1;
            end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_request(random_request(), ROW_PREDICT, '0);
         wait_for_results();
      end

      // let any late beat show up before closing
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d requests: %0d result beats, %0d rejected, %0d empty walks",
               request_count, beat_count, reject_count, empty_count);
      $display("longest walk %0d beats, %0d mismatches", longest_walk, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("watchdog expired with %0d centers outstanding", pending_centers.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule : greedy_four_connected_line_walk_tb
